/* rtl/config_line_reader_defines.svh */
// Assertion macros shared by the checker of the line reader.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef CONFIG_LINE_READER_DEFINES_SVH
`define CONFIG_LINE_READER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/clr_pkg.sv */
// Types and character constants for the line reader.
// No dependencies.
package clr_pkg;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // one result beat
    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       line_end;
        logic       line_had_input;
        logic       last;
    } result_t;

    // everything one input beat produces
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

/* rtl/clr_step.sv */
// Line parsing state and the per-byte decision logic.
// Depends on clr_pkg.
module clr_step
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            in_byte,
    input  logic                  end_of_stream,
    output clr_pkg::step_out_t    step_out
);
    import clr_pkg::*;

    logic quote_pending_reg, quote_pending_next;
    logic in_comment_reg, in_comment_next;
    logic swallow_armed_reg, swallow_armed_next;
    logic swallow_is_cr_reg, swallow_is_cr_next;
    logic line_started_reg, line_started_next;

    result_t    char_res;
    result_t    end_res;
    logic [7:0] expect_byte;
    logic       is_break;

    // result templates
    always_comb
    begin
        char_res = '0;
        char_res.char_valid = 1'b1;
        end_res = '0;
        end_res.line_end = 1'b1;
        expect_byte = swallow_is_cr_reg ? CH_CR : CH_LF;
        is_break = (in_byte == CH_LF) || (in_byte == CH_CR);
    end

    // decision for one beat
    always_comb
    begin
        step_out = '0;
        quote_pending_next = quote_pending_reg;
        in_comment_next    = in_comment_reg;
        swallow_armed_next = swallow_armed_reg;
        swallow_is_cr_next = swallow_is_cr_reg;
        line_started_next  = line_started_reg;

        if (end_of_stream)
        begin
            if (quote_pending_reg)
            begin
                step_out.count = 2'd2;
                step_out.r0 = char_res;
                step_out.r0.out_char = CH_BSLASH;
                step_out.r1 = end_res;
                step_out.r1.line_had_input = line_started_reg;
                step_out.r1.last = 1'b1;
            end
            else
            begin
                step_out.count = 2'd1;
                step_out.r0 = end_res;
                step_out.r0.line_had_input = line_started_reg;
                step_out.r0.last = 1'b1;
            end
            quote_pending_next = 1'b0;
            in_comment_next    = 1'b0;
            swallow_armed_next = 1'b0;
            swallow_is_cr_next = 1'b0;
            line_started_next  = 1'b0;
        end
        else if (swallow_armed_reg && (in_byte == expect_byte))
        begin
            // swallowed byte: no result, not counted
            swallow_armed_next = 1'b0;
        end
        else
        begin
            swallow_armed_next = 1'b0;
            line_started_next  = 1'b1;
            if (quote_pending_reg)
            begin
                quote_pending_next = 1'b0;
                if (in_byte == CH_HASH)
                begin
                    step_out.count = 2'd1;
                    step_out.r0 = char_res;
                    step_out.r0.out_char = CH_HASH;
                    step_out.r0.last = 1'b1;
                end
                else if (is_break)
                begin
                    // continuation: join lines
                    swallow_armed_next = 1'b1;
                    swallow_is_cr_next = (in_byte == CH_LF);
                end
                else
                begin
                    step_out.count = 2'd2;
                    step_out.r0 = char_res;
                    step_out.r0.out_char = CH_BSLASH;
                    step_out.r1 = char_res;
                    step_out.r1.out_char = in_byte;
                    step_out.r1.last = 1'b1;
                end
            end
            else if (in_byte == CH_HASH)
            begin
                in_comment_next = 1'b1;
            end
            else if (in_byte == CH_BSLASH)
            begin
                if (!in_comment_reg)
                begin
                    quote_pending_next = 1'b1;
                end
            end
            else if (is_break)
            begin
                step_out.count = 2'd1;
                step_out.r0 = end_res;
                step_out.r0.line_had_input = 1'b1;
                step_out.r0.last = 1'b1;
                quote_pending_next = 1'b0;
                in_comment_next    = 1'b0;
                line_started_next  = 1'b0;
                swallow_armed_next = 1'b1;
                swallow_is_cr_next = (in_byte == CH_LF);
            end
            else if (!in_comment_reg)
            begin
                step_out.count = 2'd1;
                step_out.r0 = char_res;
                step_out.r0.out_char = in_byte;
                step_out.r0.last = 1'b1;
            end
        end
    end

    // state update on each consumed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_pending_reg <= 1'b0;
            in_comment_reg    <= 1'b0;
            swallow_armed_reg <= 1'b0;
            swallow_is_cr_reg <= 1'b0;
            line_started_reg  <= 1'b0;
        end
        else if (fire)
        begin
            quote_pending_reg <= quote_pending_next;
            in_comment_reg    <= in_comment_next;
            swallow_armed_reg <= swallow_armed_next;
            swallow_is_cr_reg <= swallow_is_cr_next;
            line_started_reg  <= line_started_next;
        end
    end

endmodule

/* rtl/clr_out_buf.sv */
// Two-slot result register that drains one beat per cycle while out_stall is low.
// Depends on clr_pkg.
module clr_out_buf
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  clr_pkg::step_out_t    step_out,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_stall,
    output clr_pkg::result_t      head
);
    import clr_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       take;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && !out_stall;
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && take);
    assign head      = slot0_reg;

    // slot and count update
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            slot0_next = step_out.r0;
            slot1_next = step_out.r1;
            cnt_next   = step_out.count;
        end
        else if (take)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* rtl/config_line_reader.sv */
// Top level of the line reader: input register, parser, result buffer.
// Depends on clr_pkg, clr_step and clr_out_buf.
//
//  channel | handshake             | beat contents
//  --------+-----------------------+-----------------------------------------------
//  in      | in_valid / in_stall   | in_byte, end_of_stream
//  out     | out_valid / out_stall | char_valid, out_char, line_end, line_had_input, last
//
// One input beat per cycle while in_stall is low; a beat that yields two results holds
// the input while the result buffer drains. Each beat is registered, then loaded into the
// result buffer. Reset is asynchronous and clears parser state and both valid flags.
// in_stall rises only while the registered beat cannot move into the result buffer.
module config_line_reader
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic       line_end,
    output logic       line_had_input,
    output logic       last
);
    import clr_pkg::*;

    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       eos_reg;
    logic       can_load;
    logic       fire;
    step_out_t  step_out;
    result_t    head;

    assign fire     = in_vld_reg && can_load;
    assign in_stall = in_vld_reg && !fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= in_byte;
            eos_reg  <= end_of_stream;
        end
    end

    clr_step u_step
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .in_byte       (byte_reg),
        .end_of_stream (eos_reg),
        .step_out      (step_out)
    );

    clr_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .step_out  (step_out),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign char_valid     = head.char_valid;
    assign out_char       = head.out_char;
    assign line_end       = head.line_end;
    assign line_had_input = head.line_had_input;
    assign last           = head.last;

endmodule

/* rtl/clr_checker.sv */
// Port-level checks for the line reader, bound to the top level.
// Depends on config_line_reader_defines.svh.
`include "config_line_reader_defines.svh"

module clr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       end_of_stream,
    input logic       out_valid,
    input logic       out_stall,
    input logic       char_valid,
    input logic [7:0] out_char,
    input logic       line_end,
    input logic       line_had_input,
    input logic       last
);

    // a line end carries no character and closes its input beat
    `CLR_ASSERT_NOW(a_end_no_char, out_valid && line_end, !char_valid && out_char == 8'h00 && last, "line end carries a character or is not last")
    // a character beat never reports line input
    `CLR_ASSERT_NOW(a_char_no_had, out_valid && !line_end, char_valid && !line_had_input, "character beat malformed")
    // a stalled result holds
    `CLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(line_end), "stalled result changed")
    // a character that is not last is always followed by a further result
    `CLR_ASSERT_NEXT(a_pair_follow, out_valid && !out_stall && !last, out_valid, "second result of a pair missing")
    // a stalled input beat holds
    `CLR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_byte) && $stable(end_of_stream), "stalled input changed")

endmodule

bind config_line_reader clr_checker u_clr_checker (.*);

/* test/config_line_reader_test.sv */
// Self-checking testbench for config_line_reader: a directed table, then random byte streams.
// Results are checked against a behavioural line parser held here. Depends on clr_pkg.
module config_line_reader_test;
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    // one row of stimulus; typed rows carry their expected beats
    typedef struct packed {
        logic [7:0] byt;
        logic       eos;
        logic       typed;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } plan_row_t;

    localparam int DIRECTED  = 27;
    localparam int RANDOM    = 1825;
    localparam int TOTAL     = DIRECTED + RANDOM;
    localparam int CALM_FROM = TOTAL - 200;

    localparam result_t R_NIL   = '0;
    localparam result_t R_LINE0 = {1'b0, 8'h00, 1'b1, 1'b0, 1'b1};
    localparam result_t R_LINE1 = {1'b0, 8'h00, 1'b1, 1'b1, 1'b1};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_stream;
    logic       out_valid;
    logic       out_stall;
    logic       char_valid;
    logic [7:0] out_char;
    logic       line_end;
    logic       line_had_input;
    logic       last;

    plan_row_t  cur_row;
    plan_row_t  plan [0:DIRECTED-1];
    result_t    due_results [$];
    int         faults = 0;
    int         beats_taken = 0;
    int         stall_left = 0;

    // parser state of the behavioural model
    logic quoting    = 1'b0;
    logic in_remark  = 1'b0;
    logic drop_armed = 1'b0;
    logic drop_cr    = 1'b0;
    logic line_begun = 1'b0;

    config_line_reader u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .end_of_stream  (end_of_stream),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_valid     (char_valid),
        .out_char       (out_char),
        .line_end       (line_end),
        .line_had_input (line_had_input),
        .last           (last)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic result_t beat_of(input logic cv, input logic [7:0] ch,
                                        input logic le, input logic had);
        result_t r;
        r.char_valid     = cv;
        r.out_char       = ch;
        r.line_end       = le;
        r.line_had_input = had;
        r.last           = 1'b0;
        return r;
    endfunction

    // advance the parser by one input beat and return the beats it yields
    function automatic step_out_t parse_beat(input logic [7:0] b, input logic eos);
        step_out_t  o;
        result_t    res [0:1];
        int         n;
        logic [7:0] want;
        logic       dropped;
        n       = 0;
        res[0]  = R_NIL;
        res[1]  = R_NIL;
        dropped = 1'b0;
        if (eos)
        begin
            if (quoting)
            begin
                res[n] = beat_of(1'b1, CH_BSLASH, 1'b0, 1'b0);
                n++;
            end
            res[n] = beat_of(1'b0, 8'h00, 1'b1, line_begun);
            n++;
            quoting    = 1'b0;
            in_remark  = 1'b0;
            line_begun = 1'b0;
            drop_armed = 1'b0;
            drop_cr    = 1'b0;
        end
        else
        begin
            // the complementary byte after a line break is dropped silently
            if (drop_armed)
            begin
                want       = drop_cr ? CH_CR : CH_LF;
                drop_armed = 1'b0;
                dropped    = (b == want);
            end
            if (!dropped)
            begin
                line_begun = 1'b1;
                if (quoting)
                begin
                    quoting = 1'b0;
                    if (b == CH_HASH)
                    begin
                        res[n] = beat_of(1'b1, CH_HASH, 1'b0, 1'b0);
                        n++;
                    end
                    else if (b == CH_CR || b == CH_LF)
                    begin
                        // continuation: lines join
                        drop_armed = 1'b1;
                        drop_cr    = (b == CH_LF);
                    end
                    else
                    begin
                        res[n] = beat_of(1'b1, CH_BSLASH, 1'b0, 1'b0);
                        n++;
                        res[n] = beat_of(1'b1, b, 1'b0, 1'b0);
                        n++;
                    end
                end
                else if (b == CH_HASH)
                    in_remark = 1'b1;
                else if (b == CH_BSLASH)
                begin
                    if (!in_remark)
                        quoting = 1'b1;
                end
                else if (b == CH_LF || b == CH_CR)
                begin
                    res[n] = beat_of(1'b0, 8'h00, 1'b1, 1'b1);
                    n++;
                    quoting    = 1'b0;
                    in_remark  = 1'b0;
                    line_begun = 1'b0;
                    drop_armed = 1'b1;
                    drop_cr    = (b == CH_LF);
                end
                else if (!in_remark)
                begin
                    res[n] = beat_of(1'b1, b, 1'b0, 1'b0);
                    n++;
                end
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        o.count = 2'(n);
        o.r0    = res[0];
        o.r1    = res[1];
        return o;
    endfunction

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // output check, then prediction for the beat accepted at this edge
    always @(posedge clk)
    begin
        step_out_t so;
        result_t   got;
        result_t   want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {char_valid, out_char, line_end, line_had_input, last};
                if (due_results.size() == 0)
                    log_fault($sformatf("unexpected beat cv=%b ch=%h le=%b had=%b last=%b",
                        got.char_valid, got.out_char, got.line_end,
                        got.line_had_input, got.last));
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                        log_fault($sformatf(
                            "mismatch exp cv=%b ch=%h le=%b had=%b last=%b, got cv=%b ch=%h le=%b had=%b last=%b",
                            want.char_valid, want.out_char, want.line_end,
                            want.line_had_input, want.last,
                            got.char_valid, got.out_char, got.line_end,
                            got.line_had_input, got.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                so = parse_beat(in_byte, end_of_stream);
                if (cur_row.typed)
                begin
                    if (cur_row.n > 0)
                        due_results.push_back(cur_row.r0);
                    if (cur_row.n > 1)
                        due_results.push_back(cur_row.r1);
                end
                else
                begin
                    if (so.count > 0)
                        due_results.push_back(so.r0);
                    if (so.count > 1)
                        due_results.push_back(so.r1);
                end
                beats_taken <= beats_taken + 1;
            end
        end
    end

    // receiver stalls in bursts, none near the end
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (beats_taken < CALM_FROM && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                out_stall  = 1'b1;
                stall_left--;
            end
            else
                out_stall = 1'b0;
        end
    end

    // sender: directed table, then random streams
    initial
    begin
        plan_row_t row;
        int        gap;
        int        pick;
        int        waited;
        plan = '{
            '{8'h00,     1'b1, 1'b1, 2'd1, R_LINE0, R_NIL},                   // eos after reset
            '{8'h00,     1'b0, 1'b1, 2'd1, {1'b1, 8'h00, 3'b001}, R_NIL},
            '{8'hFF,     1'b0, 1'b1, 2'd1, {1'b1, 8'hFF, 3'b001}, R_NIL},
            '{CH_LF,     1'b0, 1'b1, 2'd1, R_LINE1, R_NIL},
            '{CH_CR,     1'b0, 1'b1, 2'd0, R_NIL, R_NIL},                     // CR after LF dropped
            '{8'h61,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_CR,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // bare CR ends line
            '{CH_LF,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_HASH,   1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // comment
            '{8'h78,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // backslash in comment
            '{CH_LF,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_HASH,   1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // quoted hash
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // quoted backslash
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{8'h7A,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // other quoted byte
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_LF,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // join on LF
            '{CH_CR,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{CH_CR,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // join on CR
            '{8'h71,     1'b0, 1'b0, 2'd0, R_NIL, R_NIL},                     // not LF: disarms
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, R_NIL, R_NIL},
            '{8'h00,     1'b1, 1'b1, 2'd2, {1'b1, CH_BSLASH, 3'b000}, R_LINE1}, // pending quote
            '{8'hFF,     1'b1, 1'b1, 2'd1, R_LINE0, R_NIL}                    // repeated eos
        };
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        end_of_stream = 1'b0;
        cur_row       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < TOTAL; i++)
        begin
            if (i < DIRECTED)
                row = plan[i];
            else
            begin
                // mostly text with markup, some raw bytes, rare end of stream
                row  = '0;
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    row.byt = 8'($urandom_range(8'h61, 8'h7A));
                else if (pick < 50)
                    row.byt = CH_HASH;
                else if (pick < 62)
                    row.byt = CH_BSLASH;
                else if (pick < 73)
                    row.byt = CH_LF;
                else if (pick < 84)
                    row.byt = CH_CR;
                else
                    row.byt = 8'($urandom_range(0, 255));
                if (pick >= 98)
                    row.eos = 1'b1;
            end
            if (beats_taken < CALM_FROM && $urandom_range(0, 5) == 0)
            begin
                in_valid = 1'b0;
                gap      = $urandom_range(1, 9);
                repeat (gap)
                begin
                    in_byte       = 8'($urandom_range(0, 255));
                    end_of_stream = 1'($urandom_range(0, 1));
                    @(negedge clk);
                end
            end
            cur_row       = row;
            in_byte       = row.byt;
            end_of_stream = row.eos;
            in_valid      = 1'b1;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
        end
        in_valid = 1'b0;

        // drain, then wait for stray beats
        waited = 0;
        while (due_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
            log_fault($sformatf("%0d expected beats never arrived", due_results.size()));
        if (faults == 0)
            $display("config_line_reader_test: PASS");
        else
            $display("config_line_reader_test: FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #5_000_000;
        $display("config_line_reader_test: FAIL");
        $finish;
    end

endmodule
